/* hw/rtl/icrs_pkg.sv */
`timescale 1ns / 1ps

package icrs_pkg;

    localparam int MAX_POSITIONS_DEF  = 1024;
    localparam int MAX_COVARIANCE_DEF = 16;

    localparam int POS_W       = 10;
    localparam int REQ_W       = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int MPD_W       = 10;
    localparam int MHL_W       = 9;
    localparam int SEQ_W       = 11;
    localparam int LIST_CNT_W  = 11;
    localparam int COV_CNT_W   = 5;
    localparam int RES_W       = 11;
    localparam int SPAN_W      = 12;
    localparam int ARITH_W     = 14;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 24;

    localparam logic [REQ_W-1:0] REQ_LOAD_LIST = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_HEAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PAIR_DISTANCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HELIX_LENGTH  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEQUENCE_LENGTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIST_COUNT        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_COVARIANCE_COUNT  = 3'd4;

    localparam logic [MPD_W-1:0] MPD_RESET = 10'd3;
    localparam logic [MHL_W-1:0] MHL_RESET = 9'd1;

    localparam logic [RES_W-1:0] NONE_VALUE = '1;

    typedef enum logic [1:0] {
        END_KEEP,
        END_FIT,
        END_CUR,
        END_RD
    } end_sel_t;

    typedef struct packed {
        logic     capture;
        logic     rec_scan;
        logic     fit;
        logic     next_idx;
        logic     next_hidx;
        end_sel_t end_sel;
        logic     load_out;
    } icrs_cmd_t;

    typedef struct packed {
        logic exists;
        logic list_empty;
        logic below;
        logic above;
        logic fit;
        logic last;
        logic cov_empty;
        logic head_hit;
        logic head_last;
        logic begin_set;
        logic out_free;
    } icrs_status_t;

endpackage

/* hw/rtl/icrs_ram.sv */
`timescale 1ns / 1ps

module icrs_ram #(
    parameter int WIDTH  = 10,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/icrs_ctrl.sv */
`timescale 1ns / 1ps

module icrs_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [icrs_pkg::REQ_W-1:0]  in_type,
    output logic                        in_ready,
    input  icrs_pkg::icrs_status_t      st,
    output icrs_pkg::icrs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LIST_WAIT,
        ST_LIST_EVAL,
        ST_HEAD_WAIT,
        ST_HEAD_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid && ready_reg && (in_type == icrs_pkg::REQ_QUERY)) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (st.exists && !st.list_empty) begin
                    state_next = ST_LIST_EVAL;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_LIST_WAIT: begin
                state_next = ST_LIST_EVAL;
            end
            ST_LIST_EVAL: begin
                cmd.rec_scan = 1'b1;
                priority if (st.above && !st.below) begin
                    if (st.begin_set) begin
                        cmd.end_sel = icrs_pkg::END_FIT;
                    end
                    state_next = ST_FINISH;
                end else if (st.fit && !st.below) begin
                    cmd.fit = 1'b1;
                    if (!st.cov_empty) begin
                        state_next = ST_HEAD_WAIT;
                    end else if (st.last) begin
                        cmd.end_sel = icrs_pkg::END_RD;
                        state_next  = ST_FINISH;
                    end else begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_LIST_WAIT;
                    end
                end else begin
                    if (st.last) begin
                        if (st.begin_set) begin
                            cmd.end_sel = icrs_pkg::END_RD;
                        end
                        state_next = ST_FINISH;
                    end else begin
                        cmd.next_idx = 1'b1;
                        state_next   = ST_LIST_WAIT;
                    end
                end
            end
            ST_HEAD_WAIT: begin
                state_next = ST_HEAD_EVAL;
            end
            ST_HEAD_EVAL: begin
                priority if (st.head_hit) begin
                    cmd.end_sel = icrs_pkg::END_CUR;
                    state_next  = ST_FINISH;
                end else if (!st.head_last) begin
                    cmd.next_hidx = 1'b1;
                    state_next    = ST_HEAD_WAIT;
                end else if (st.last) begin
                    cmd.end_sel = icrs_pkg::END_CUR;
                    state_next  = ST_FINISH;
                end else begin
                    cmd.next_idx = 1'b1;
                    state_next   = ST_LIST_WAIT;
                end
            end
            ST_FINISH: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

/* hw/rtl/icrs_datapath.sv */
`timescale 1ns / 1ps

module icrs_datapath #(
    parameter int MAX_POSITIONS  = icrs_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_COVARIANCE = icrs_pkg::MAX_COVARIANCE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [icrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [icrs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_accept,
    input  logic [icrs_pkg::REQ_W-1:0]        in_type,
    input  logic [icrs_pkg::S_TDATA_W-1:0]    in_data,
    input  icrs_pkg::icrs_cmd_t               cmd,
    output icrs_pkg::icrs_status_t            st,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [icrs_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int AW   = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int HAW  = (MAX_COVARIANCE > 1) ? $clog2(MAX_COVARIANCE) : 1;
    localparam int LCW  = ($clog2(MAX_POSITIONS + 1) > icrs_pkg::LIST_CNT_W) ?
                          $clog2(MAX_POSITIONS + 1) : icrs_pkg::LIST_CNT_W;
    localparam int CW   = ($clog2(MAX_COVARIANCE + 1) > icrs_pkg::COV_CNT_W) ?
                          $clog2(MAX_COVARIANCE + 1) : icrs_pkg::COV_CNT_W;
    localparam int PW   = icrs_pkg::POS_W;
    localparam int AR_W = icrs_pkg::ARITH_W;

    logic [icrs_pkg::MPD_W-1:0]      mpd_reg;
    logic [icrs_pkg::MHL_W-1:0]      mhl_reg;
    logic [icrs_pkg::SEQ_W-1:0]      seq_len_reg;
    logic [icrs_pkg::LIST_CNT_W-1:0] list_cnt_reg;
    logic [icrs_pkg::COV_CNT_W-1:0]  cov_cnt_reg;

    logic [PW-1:0] in_slot;
    logic [PW-1:0] in_start;
    logic [PW-1:0] in_close;
    logic [PW-1:0] in_row;
    logic [PW-1:0] in_col;
    logic [LCW-1:0] slot_ext;

    logic [icrs_pkg::SPAN_W-1:0] span;
    logic signed [AR_W-1:0]      bound_next;
    logic signed [AR_W-1:0]      min_col;
    logic                        exists;

    logic [PW-1:0]          row_reg;
    logic [PW-1:0]          col_reg;
    logic signed [AR_W-1:0] bound_reg;
    logic [LCW-1:0]         idx_reg;
    logic [CW-1:0]          hidx_reg;
    logic [PW-1:0]          cur_v_reg;
    logic [PW-1:0]          fit_v_reg;
    logic [icrs_pkg::RES_W-1:0] begin_reg;
    logic [icrs_pkg::RES_W-1:0] end_reg;
    logic                   begin_set_reg;

    logic [LCW-1:0] list_n;
    logic [LCW-1:0] list_cnt_ext;
    logic [LCW-1:0] idx_inc;
    logic [CW-1:0]  cov_n;
    logic [CW-1:0]  cov_cnt_ext;
    logic [CW-1:0]  hidx_inc;

    logic            list_we;
    logic            head_we;
    logic [2*PW-1:0] list_rdata;
    logic [PW-1:0]   rd_start;
    logic [PW-1:0]   rd_close;
    logic [PW-1:0]   head_rdata;

    logic                          m_tvalid_reg;
    logic [icrs_pkg::M_TDATA_W-1:0] m_tdata_reg;

    assign in_slot  = in_data[PW-1:0];
    assign in_start = in_data[2*PW-1:PW];
    assign in_close = in_data[3*PW-1:2*PW];
    assign in_row   = in_data[4*PW-1:3*PW];
    assign in_col   = in_data[5*PW-1:4*PW];
    assign slot_ext = LCW'(in_slot);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpd_reg      <= icrs_pkg::MPD_RESET;
            mhl_reg      <= icrs_pkg::MHL_RESET;
            seq_len_reg  <= '0;
            list_cnt_reg <= '0;
            cov_cnt_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                icrs_pkg::CFG_MIN_PAIR_DISTANCE: mpd_reg      <= cfg_data[icrs_pkg::MPD_W-1:0];
                icrs_pkg::CFG_MIN_HELIX_LENGTH:  mhl_reg      <= cfg_data[icrs_pkg::MHL_W-1:0];
                icrs_pkg::CFG_SEQUENCE_LENGTH:   seq_len_reg  <= cfg_data[icrs_pkg::SEQ_W-1:0];
                icrs_pkg::CFG_LIST_COUNT:        list_cnt_reg <= cfg_data[icrs_pkg::LIST_CNT_W-1:0];
                icrs_pkg::CFG_COVARIANCE_COUNT:  cov_cnt_reg  <= cfg_data[icrs_pkg::COV_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The span is the minimum gap plus both helix arms.
    assign span       = {2'b00, mpd_reg} + {2'b00, mhl_reg, 1'b0};
    assign bound_next = $signed(AR_W'(in_col)) - $signed(AR_W'(span)) + AR_W'(1);
    assign min_col    = $signed(AR_W'(row_reg)) + $signed(AR_W'(span)) - AR_W'(3);
    assign exists     = ({1'b0, col_reg} < seq_len_reg) &&
                        ($signed(AR_W'(col_reg)) >= min_col);

    assign list_cnt_ext = LCW'(list_cnt_reg);
    assign list_n       = (list_cnt_ext > LCW'(MAX_POSITIONS)) ? LCW'(MAX_POSITIONS)
                                                                : list_cnt_ext;
    assign cov_cnt_ext  = CW'(cov_cnt_reg);
    assign cov_n        = (cov_cnt_ext > CW'(MAX_COVARIANCE)) ? CW'(MAX_COVARIANCE)
                                                               : cov_cnt_ext;
    assign idx_inc      = idx_reg + LCW'(1);
    assign hidx_inc     = hidx_reg + CW'(1);

    assign list_we = in_accept && (in_type == icrs_pkg::REQ_LOAD_LIST) &&
                     (slot_ext < LCW'(MAX_POSITIONS));
    assign head_we = in_accept && (in_type == icrs_pkg::REQ_LOAD_HEAD) &&
                     (slot_ext < LCW'(MAX_COVARIANCE));

    icrs_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_POSITIONS),
        .ADDR_W(AW)
    ) u_list_ram (
        .aclk (aclk),
        .we   (list_we),
        .waddr(slot_ext[AW-1:0]),
        .wdata({in_close, in_start}),
        .raddr(idx_reg[AW-1:0]),
        .rdata(list_rdata)
    );

    icrs_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_COVARIANCE),
        .ADDR_W(HAW)
    ) u_head_ram (
        .aclk (aclk),
        .we   (head_we),
        .waddr(slot_ext[HAW-1:0]),
        .wdata(in_start),
        .raddr(hidx_reg[HAW-1:0]),
        .rdata(head_rdata)
    );

    assign rd_start = list_rdata[PW-1:0];
    assign rd_close = list_rdata[2*PW-1:PW];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            row_reg   <= in_row;
            col_reg   <= in_col;
            bound_reg <= bound_next;
        end
        if (cmd.rec_scan) begin
            cur_v_reg <= rd_start;
        end
        if (cmd.fit) begin
            fit_v_reg <= rd_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            hidx_reg      <= '0;
            begin_reg     <= icrs_pkg::NONE_VALUE;
            end_reg       <= icrs_pkg::NONE_VALUE;
            begin_set_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                idx_reg       <= '0;
                begin_reg     <= icrs_pkg::NONE_VALUE;
                end_reg       <= icrs_pkg::NONE_VALUE;
                begin_set_reg <= 1'b0;
            end else if (cmd.next_idx) begin
                idx_reg <= idx_inc;
            end
            if (cmd.rec_scan) begin
                hidx_reg <= '0;
            end else if (cmd.next_hidx) begin
                hidx_reg <= hidx_inc;
            end
            if (cmd.fit && !begin_set_reg) begin
                begin_reg     <= {1'b0, rd_start};
                begin_set_reg <= 1'b1;
            end
            unique case (cmd.end_sel)
                icrs_pkg::END_FIT: end_reg <= {1'b0, fit_v_reg};
                icrs_pkg::END_CUR: end_reg <= {1'b0, cur_v_reg};
                icrs_pkg::END_RD:  end_reg <= {1'b0, rd_start};
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        st            = '0;
        st.exists     = exists;
        st.list_empty = (list_n == '0);
        st.below      = (rd_start < row_reg);
        st.above      = ($signed(AR_W'(rd_start)) > bound_reg);
        st.fit        = (rd_close <= col_reg);
        st.last       = (idx_inc >= list_n);
        st.cov_empty  = (cov_n == '0);
        st.head_hit   = (head_rdata == cur_v_reg);
        st.head_last  = (hidx_inc >= cov_n);
        st.begin_set  = begin_set_reg;
        st.out_free   = !m_tvalid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {1'b0, end_reg, begin_reg, exists};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hw/rtl/interval_cell_range_scan_top.sv */
`timescale 1ns / 1ps

// Interval cell range scan. Items arrive on the s_ channel; tuser gives the kind
// of item: load a list entry, load a covariance head, or query a cell.
// Load items write one in-range table slot, leave the block idle and give no result.
// A query checks that the cell exists, then scans the component list one entry
// at a time from slot 0, and returns one item on the m_ channel with the
// existence flag and the begin and end values (all ones meaning none).
// A query holds off the input while it scans list entries and compares heads,
// and takes no new item until its result is loaded into the output register.
// Every fitting entry is checked against the heads one at a time through the
// head memory. Both tables sit in memories with a registered read, so each step
// has a read state and an evaluation state; the first entry is read during the
// existence check. Registers are written on the cfg_ channel, which is always
// ready; the user must write them only while the block is idle, as the block
// itself does not enforce this. Reset restores the register defaults and empties
// the output; the tables are undefined until loaded. A stalled receiver holds the
// result in the output register; further items are accepted meanwhile, and a
// query then waits at its end until the output register is free.
module interval_cell_range_scan_top #(
    parameter int MAX_POSITIONS  = icrs_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_COVARIANCE = icrs_pkg::MAX_COVARIANCE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot, start_position, close_position, row, col
    input  logic [icrs_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type
    input  logic [icrs_pkg::REQ_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cell_exists, begin_value, end_value
    output logic [icrs_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [icrs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [icrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    icrs_pkg::icrs_cmd_t    cmd;
    icrs_pkg::icrs_status_t st;
    logic                   in_accept;

    assign in_accept = s_tvalid && s_tready;

    icrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_tvalid),
        .in_type (s_tuser),
        .in_ready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    icrs_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_COVARIANCE(MAX_COVARIANCE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_accept(in_accept),
        .in_type  (s_tuser),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
